// ===== hdl/display_frame_format_converter_defines.svh =====
// Assertion macros shared by the display frame format converter RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef DISPLAY_FRAME_FORMAT_CONVERTER_DEFINES_SVH
`define DISPLAY_FRAME_FORMAT_CONVERTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define DFFC_ASSERT_NOW(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("display frame format converter check failed");

// Next-cycle implication, disabled while reset is high.
`define DFFC_ASSERT_NEXT(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("display frame format converter check failed");

`endif

// ===== hdl/dffc_pkg.sv =====
// Package for the display frame format converter: panel constants, register
// indexes, mode codes and the request and response payload types. No dependencies.
package dffc_pkg;

   localparam int MONO_COLUMNS = 132;
   localparam int MONO_PAGES   = 8;
   localparam int OLED_SIDE    = 64;

   localparam int PIXEL_W    = 8;
   localparam int INDEX_W    = 10;
   localparam int ADDRESS_W  = 20;
   localparam int MODE_W     = 2;
   localparam int DIM_W      = 11;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_INDEX_W = 3;

   localparam logic [PIXEL_W-1:0] MONO_THRESHOLD = 8'd108;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_PANEL_MODE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERT_MASK  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLIP_ENABLE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 3'd4;

   // Panel modes; the unused code behaves as plain 8bpp.
   localparam logic [MODE_W-1:0] MODE_MONO = 2'd0;
   localparam logic [MODE_W-1:0] MODE_OLED = 2'd1;
   localparam logic [MODE_W-1:0] MODE_8BPP = 2'd2;

   localparam logic [DIM_W-1:0] FRAME_DIM_RESET = 11'd32;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_0;
      logic [PIXEL_W-1:0] pixel_1;
      logic [PIXEL_W-1:0] pixel_2;
      logic [PIXEL_W-1:0] pixel_3;
      logic [PIXEL_W-1:0] pixel_4;
      logic [PIXEL_W-1:0] pixel_5;
      logic [PIXEL_W-1:0] pixel_6;
      logic [PIXEL_W-1:0] pixel_7;
      logic [INDEX_W-1:0] column_index;
      logic [INDEX_W-1:0] row_index;
   } req_payload_type;

   typedef struct packed {
      logic [ADDRESS_W-1:0] dest_address;
      logic [PIXEL_W-1:0]   dest_byte;
   } rsp_payload_type;

endpackage

// ===== hdl/display_frame_format_converter.sv =====
// Display frame format converter: one transaction of frame-buffer pixels in,
// one panel byte and its write-buffer address out. Uses dffc_pkg and the defines header.
//
// The request and the result are each registered; the result strobe rises in the cycle after the edge that takes start.
// Throughput: one transaction per cycle outside reset; the address path holds one 20x11 multiplier.
// busy is high only while reset is high; the receiver cannot stall the result.
// Synchronous reset clears the pipeline valids and loads register defaults.
`include "display_frame_format_converter_defines.svh"

module display_frame_format_converter (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  dffc_pkg::req_payload_type             req_payload,
   output logic                                  rsp_strobe,
   output dffc_pkg::rsp_payload_type             rsp_payload,
   input  logic                                  csr_write_enable,
   input  logic [dffc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [dffc_pkg::CSR_DATA_W-1:0]       csr_write_data
);
   import dffc_pkg::*;

   localparam int PRODUCT_W = ADDRESS_W + DIM_W;

   logic [MODE_W-1:0]  panel_mode_ff;
   logic [PIXEL_W-1:0] invert_mask_ff;
   logic               flip_enable_ff;
   logic [DIM_W-1:0]   frame_width_ff;
   logic [DIM_W-1:0]   frame_height_ff;

   logic            req_valid_ff;
   req_payload_type req_data_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type rsp_data_in;

   logic                 accept;
   logic [PIXEL_W-1:0]   mono_bits;
   logic [PIXEL_W-1:0]   mono_byte;
   logic [PIXEL_W-1:0]   oled_byte;
   logic [PIXEL_W-1:0]   out_byte;
   logic [ADDRESS_W-1:0] lines;
   logic [DIM_W-1:0]     per_line;
   logic [ADDRESS_W-1:0] row_sel;
   logic [ADDRESS_W-1:0] col_sel;
   logic [PRODUCT_W-1:0] product;

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         panel_mode_ff   <= MODE_MONO;
         invert_mask_ff  <= '0;
         flip_enable_ff  <= 1'b0;
         frame_width_ff  <= FRAME_DIM_RESET;
         frame_height_ff <= FRAME_DIM_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_PANEL_MODE:   panel_mode_ff   <= csr_write_data[MODE_W-1:0];
            CSR_INVERT_MASK:  invert_mask_ff  <= csr_write_data[PIXEL_W-1:0];
            CSR_FLIP_ENABLE:  flip_enable_ff  <= csr_write_data[0];
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_write_data[DIM_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_write_data[DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      mono_bits[0] = req_data_ff.pixel_0 >= MONO_THRESHOLD;
      mono_bits[1] = req_data_ff.pixel_1 >= MONO_THRESHOLD;
      mono_bits[2] = req_data_ff.pixel_2 >= MONO_THRESHOLD;
      mono_bits[3] = req_data_ff.pixel_3 >= MONO_THRESHOLD;
      mono_bits[4] = req_data_ff.pixel_4 >= MONO_THRESHOLD;
      mono_bits[5] = req_data_ff.pixel_5 >= MONO_THRESHOLD;
      mono_bits[6] = req_data_ff.pixel_6 >= MONO_THRESHOLD;
      mono_bits[7] = req_data_ff.pixel_7 >= MONO_THRESHOLD;
      mono_byte = mono_bits ^ invert_mask_ff;
      if (flip_enable_ff) begin
         for (int k = 0; k < PIXEL_W; k++) begin
            mono_byte[k] = mono_bits[PIXEL_W-1-k] ^ invert_mask_ff[PIXEL_W-1-k];
         end
      end

      // The OLED inversion is 255 minus the byte, which is a bitwise complement.
      oled_byte = {req_data_ff.pixel_0[7:4], req_data_ff.pixel_1[7:4]};
      if (invert_mask_ff != '0) begin
         oled_byte = ~oled_byte;
      end
      if (flip_enable_ff) begin
         oled_byte = {oled_byte[3:0], oled_byte[7:4]};
      end

      case (panel_mode_ff)
         MODE_MONO: begin
            out_byte = mono_byte;
            lines    = ADDRESS_W'(MONO_PAGES);
            per_line = DIM_W'(MONO_COLUMNS);
         end
         MODE_OLED: begin
            out_byte = oled_byte;
            lines    = ADDRESS_W'(OLED_SIDE);
            per_line = DIM_W'(OLED_SIDE);
         end
         default: begin
            out_byte = req_data_ff.pixel_0 ^ invert_mask_ff;
            lines    = ADDRESS_W'(frame_height_ff);
            per_line = frame_width_ff;
         end
      endcase

      // Mirrored indexes wrap modulo the address width, as does the sum.
      if (flip_enable_ff) begin
         row_sel = lines - ADDRESS_W'(1) - ADDRESS_W'(req_data_ff.row_index);
         col_sel = ADDRESS_W'(per_line) - ADDRESS_W'(1)
                   - ADDRESS_W'(req_data_ff.column_index);
      end else begin
         row_sel = ADDRESS_W'(req_data_ff.row_index);
         col_sel = ADDRESS_W'(req_data_ff.column_index);
      end
      product = PRODUCT_W'(row_sel) * PRODUCT_W'(per_line);

      rsp_data_in.dest_address = product[ADDRESS_W-1:0] + col_sel;
      rsp_data_in.dest_byte    = out_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= accept;
         rsp_valid_ff <= req_valid_ff;
      end
      if (accept) begin
         req_data_ff <= req_payload;
      end
      if (req_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   `DFFC_ASSERT_NEXT(a_accept_enters_pipe, clock, reset, accept, req_valid_ff)
   `DFFC_ASSERT_NEXT(a_pipe_gives_result, clock, reset, req_valid_ff, rsp_strobe)
   `DFFC_ASSERT_NEXT(a_no_result_invented, clock, reset, !req_valid_ff, !rsp_strobe)
   `DFFC_ASSERT_NEXT(a_oled_plain_low_nibble, clock, reset,
      req_valid_ff && panel_mode_ff == MODE_OLED && invert_mask_ff == '0 && !flip_enable_ff,
      rsp_payload.dest_byte[3:0] == $past(req_data_ff.pixel_1[7:4]))
   `DFFC_ASSERT_NOW(a_busy_only_in_reset, clock, reset, 1'b1, !busy)

endmodule

// ===== tb/tb_display_frame_format_converter.sv =====
// Self-checking testbench for display_frame_format_converter: directed and random
// pixel transactions in all panel modes, checked against an in-bench predictor.
// Depends on dffc_pkg and the converter RTL only.
module tb_display_frame_format_converter;
   timeunit 1ns;
   timeprecision 1ps;

   import dffc_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNDEFINED = 2'd3;
   localparam int MAX_REPORTS = 40;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        start;
   logic                        busy;
   req_payload_type             req_payload;
   logic                        rsp_strobe;
   rsp_payload_type             rsp_payload;
   logic                        csr_write_enable;
   logic [CSR_INDEX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]       csr_write_data;

   // Shadow copy of the panel registers, updated as each write is taken.
   logic [MODE_W-1:0]  cur_mode   = MODE_MONO;
   logic [7:0]         cur_invert = '0;
   logic               cur_flip   = 1'b0;
   logic [DIM_W-1:0]   cur_width  = FRAME_DIM_RESET;
   logic [DIM_W-1:0]   cur_height = FRAME_DIM_RESET;

   rsp_payload_type expected_bytes[$];
   int items_sent    = 0;
   int bytes_checked = 0;
   int error_count   = 0;

   display_frame_format_converter dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_payload      (req_payload),
      .rsp_strobe       (rsp_strobe),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Expected panel byte and buffer address for one transaction under the
   // current register settings. Address math wraps like a 32-bit counter and
   // keeps the low 20 bits.
   function automatic rsp_payload_type predict_panel_byte(input req_payload_type r);
      logic [63:0]     pixels;
      logic [7:0]      bits;
      logic [7:0]      value;
      logic [31:0]     row;
      logic [31:0]     col;
      logic [31:0]     lines;
      logic [31:0]     per_line;
      logic [31:0]     addr;
      rsp_payload_type res;
      pixels = {r.pixel_0, r.pixel_1, r.pixel_2, r.pixel_3,
                r.pixel_4, r.pixel_5, r.pixel_6, r.pixel_7};
      row = 32'(r.row_index);
      col = 32'(r.column_index);
      if (cur_mode == MODE_MONO) begin
         bits = '0;
         for (int k = 0; k < 8; k++)
            if (pixels[63-8*k -: 8] >= MONO_THRESHOLD) bits[k] = 1'b1;
         value = bits ^ cur_invert;
         if (cur_flip) begin
            for (int k = 0; k < 8; k++) bits[7-k] = value[k];
            value = bits;
         end
         lines    = MONO_PAGES;
         per_line = MONO_COLUMNS;
      end else if (cur_mode == MODE_OLED) begin
         value = {r.pixel_0[7:4], r.pixel_1[7:4]};
         if (cur_invert != 8'd0) value = 8'hFF - value;
         if (cur_flip) value = {value[3:0], value[7:4]};
         lines    = OLED_SIDE;
         per_line = OLED_SIDE;
      end else begin
         value    = r.pixel_0 ^ cur_invert;
         lines    = 32'(cur_height);
         per_line = 32'(cur_width);
      end
      if (cur_flip) begin
         row = lines - 32'd1 - row;
         col = per_line - 32'd1 - col;
      end
      addr = row * per_line + col;
      res.dest_address = addr[ADDRESS_W-1:0];
      res.dest_byte    = value;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
   endtask

   // Result checking and expectation capture share one clock edge; the result
   // of a transaction shows up only after its request and response registers, so order is safe.
   always @(posedge clock) begin : check_results
      rsp_payload_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch("unexpected result, address", '0, 32'(rsp_payload.dest_address));
            end else begin
               want = expected_bytes.pop_front();
               bytes_checked++;
               if (rsp_payload.dest_address !== want.dest_address)
                  report_mismatch("dest_address", 32'(want.dest_address),
                                  32'(rsp_payload.dest_address));
               if (rsp_payload.dest_byte !== want.dest_byte)
                  report_mismatch("dest_byte", 32'(want.dest_byte), 32'(rsp_payload.dest_byte));
            end
         end
         if (start && !busy) begin
            expected_bytes.push_back(predict_panel_byte(req_payload));
            items_sent++;
         end
      end
   end

   // Pixel bytes are given as one word with pixel_0 in the top byte, which
   // matches the packed field order of the request.
   function automatic req_payload_type make_request(input logic [63:0] pix,
                                                    input logic [INDEX_W-1:0] col,
                                                    input logic [INDEX_W-1:0] row);
      return {pix, col, row};
   endfunction

   // start is left high on return so back-to-back transactions need no gap.
   task automatic send_request(input req_payload_type r);
      @(negedge clock);
      req_payload <= r;
      start       <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic wait_drained;
      idle_cycles(1);
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         CSR_PANEL_MODE:   cur_mode   = data[MODE_W-1:0];
         CSR_INVERT_MASK:  cur_invert = data[7:0];
         CSR_FLIP_ENABLE:  cur_flip   = data[0];
         CSR_FRAME_WIDTH:  cur_width  = data;
         CSR_FRAME_HEIGHT: cur_height = data;
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic apply_settings(input logic [MODE_W-1:0] mode, input logic [7:0] invert,
                                 input logic flip, input logic [DIM_W-1:0] width,
                                 input logic [DIM_W-1:0] height);
      wait_drained();
      write_register(CSR_PANEL_MODE, CSR_DATA_W'(mode));
      write_register(CSR_INVERT_MASK, CSR_DATA_W'(invert));
      write_register(CSR_FLIP_ENABLE, CSR_DATA_W'(flip));
      write_register(CSR_FRAME_WIDTH, width);
      write_register(CSR_FRAME_HEIGHT, height);
   endtask

   function automatic logic [DIM_W-1:0] pick_dimension();
      case ($urandom_range(0, 7))
         0:       return 11'd1;
         1:       return 11'd1024;
         2:       return 11'd2047;
         3:       return 11'd0;
         4:       return DIM_W'($urandom_range(1, 1024));
         default: return DIM_W'($urandom_range(1, 64));
      endcase
   endfunction

   // Mostly in-panel coordinates, with a tenth of them anywhere in the field.
   function automatic req_payload_type random_request();
      logic [63:0]        pix;
      logic [INDEX_W-1:0] col;
      logic [INDEX_W-1:0] row;
      int                 col_lim;
      int                 row_lim;
      for (int k = 0; k < 8; k++)
         pix[8*k +: 8] = $urandom_range(0, 1) ? 8'($urandom_range(100, 115))
                                              : 8'($urandom_range(0, 255));
      if (cur_mode == MODE_MONO) begin
         col_lim = MONO_COLUMNS;
         row_lim = MONO_PAGES;
      end else if (cur_mode == MODE_OLED) begin
         col_lim = OLED_SIDE;
         row_lim = OLED_SIDE;
      end else begin
         col_lim = (cur_width == 0 || cur_width > 1024) ? 1024 : int'(cur_width);
         row_lim = (cur_height == 0 || cur_height > 1024) ? 1024 : int'(cur_height);
      end
      col = ($urandom_range(0, 9) == 0) ? INDEX_W'($urandom_range(0, 1023))
                                        : INDEX_W'($urandom_range(0, col_lim - 1));
      row = ($urandom_range(0, 9) == 0) ? INDEX_W'($urandom_range(0, 1023))
                                        : INDEX_W'($urandom_range(0, row_lim - 1));
      return make_request(pix, col, row);
   endfunction

   task automatic test_reset_defaults;
      send_request(make_request({8{8'hFF}}, 10'd131, 10'd7));
      send_request(make_request({8{8'h00}}, 10'd0, 10'd0));
      // Plain 8bpp with the frame size still at its reset value.
      wait_drained();
      write_register(CSR_PANEL_MODE, CSR_DATA_W'(MODE_8BPP));
      send_request(make_request(64'hA5000000_00000000, 10'd31, 10'd31));
   endtask

   task automatic test_mono_packing;
      apply_settings(MODE_MONO, 8'h00, 1'b0, 11'd32, 11'd32);
      // Pixels alternate just below and right at the threshold.
      send_request(make_request(64'h6B6C6B6C_6B6C6B6C, 10'd5, 10'd3));
      apply_settings(MODE_MONO, 8'hA5, 1'b0, 11'd32, 11'd32);
      send_request(make_request(64'h6C6B6CFF_00806B6C, 10'd131, 10'd7));
      apply_settings(MODE_MONO, 8'h0F, 1'b1, 11'd32, 11'd32);
      send_request(make_request(64'hFF6C0000_6B6BFF00, 10'd0, 10'd0));
      // Coordinates beyond the panel make the mirrored address wrap.
      send_request(make_request(64'h80706050_40302010, 10'd1023, 10'd1023));
   endtask

   task automatic test_oled_packing;
      apply_settings(MODE_OLED, 8'h00, 1'b0, 11'd32, 11'd32);
      send_request(make_request(64'hF35F0000_00000000, 10'd63, 10'd63));
      apply_settings(MODE_OLED, 8'h01, 1'b0, 11'd32, 11'd32);
      send_request(make_request(64'h3CC3FFFF_FFFFFFFF, 10'd0, 10'd1));
      apply_settings(MODE_OLED, 8'h00, 1'b1, 11'd32, 11'd32);
      send_request(make_request(64'h9A470000_00000000, 10'd1, 10'd0));
      apply_settings(MODE_OLED, 8'h80, 1'b1, 11'd32, 11'd32);
      send_request(make_request(64'h00FF0000_00000000, 10'd1023, 10'd64));
   endtask

   task automatic test_plain_8bpp;
      apply_settings(MODE_8BPP, 8'h00, 1'b0, 11'd1024, 11'd1024);
      send_request(make_request(64'h7F000000_00000000, 10'd1023, 10'd1023));
      apply_settings(MODE_8BPP, 8'h3C, 1'b1, 11'd1024, 11'd1024);
      send_request(make_request(64'hC3000000_00000000, 10'd0, 10'd0));
      apply_settings(MODE_8BPP, 8'h00, 1'b1, 11'd1, 11'd1);
      send_request(make_request(64'h01000000_00000000, 10'd0, 10'd0));
      // A zero frame size is not caught; the mirrored address wraps.
      apply_settings(MODE_8BPP, 8'h00, 1'b1, 11'd0, 11'd0);
      send_request(make_request(64'h80000000_00000000, 10'd17, 10'd9));
      apply_settings(MODE_8BPP, 8'hFF, 1'b1, 11'd2047, 11'd2047);
      send_request(make_request(64'h5AFFFFFF_FFFFFFFF, 10'd512, 10'd1000));
   endtask

   // The spare mode code must act as plain 8bpp.
   task automatic test_undefined_mode;
      apply_settings(MODE_UNDEFINED, 8'h55, 1'b0, 11'd100, 11'd50);
      send_request(make_request(64'hF0000000_00000000, 10'd99, 10'd49));
      apply_settings(MODE_UNDEFINED, 8'h55, 1'b1, 11'd100, 11'd50);
      send_request(make_request(64'h0F000000_00000000, 10'd3, 10'd4));
   endtask

   // Writes to indexes past the register list must leave every register alone.
   task automatic test_unused_registers;
      apply_settings(MODE_OLED, 8'h00, 1'b0, 11'd32, 11'd32);
      for (int i = int'(CSR_FRAME_HEIGHT) + 1; i < (1 << CSR_INDEX_W); i++)
         write_register(CSR_INDEX_W'(i), '1);
      send_request(make_request(64'hE7180000_00000000, 10'd10, 10'd20));
   endtask

   task automatic test_random_traffic;
      logic [7:0]        invert;
      logic [MODE_W-1:0] mode;
      int                burst_left;
      bit                no_gaps;
      for (int phase = 0; phase < 10; phase++) begin
         mode = (phase < 8) ? MODE_W'(phase % 3) : MODE_W'($urandom_range(0, 3));
         case ($urandom_range(0, 3))
            0:       invert = 8'h00;
            1:       invert = 8'hFF;
            default: invert = 8'($urandom_range(0, 255));
         endcase
         apply_settings(mode, invert, 1'($urandom_range(0, 1)), pick_dimension(),
                        pick_dimension());
         no_gaps    = (phase == 4);
         burst_left = $urandom_range(1, 16);
         for (int i = 0; i < 70; i++) begin
            send_request(random_request());
            // Once, hold the next transaction until the pipeline has emptied.
            if (phase == 2 && i == 35) wait_drained();
            burst_left--;
            if (burst_left == 0) begin
               if (!no_gaps) idle_cycles($urandom_range(0, 6));
               burst_left = $urandom_range(1, 16);
            end
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_payload      = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_mono_packing();
      test_oled_packing();
      test_plain_8bpp();
      test_undefined_mode();
      test_unused_registers();
      test_random_traffic();

      wait_drained();
      repeat (5) @(posedge clock);
      if (expected_bytes.size() != 0) begin
         error_count += expected_bytes.size();
         $display("%0t ns: %0d results never arrived", $time, expected_bytes.size());
      end
      $display("Sent %0d pixel transactions over mono, oled, 8bpp and the spare mode code;",
               items_sent);
      $display("checked %0d panel bytes, %0d errors.", bytes_checked, error_count);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("%0t ns: run timed out", $time);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
